FILE: rtl/ssts_pkg.sv
// ----------------------------------------------------------------------------
// ssts_pkg
// Shared types and constants for the synced sample trigger sequencer.
// ----------------------------------------------------------------------------
package ssts_pkg;

   // Sequencer phases, as reported on the result channel
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_COARSE = 3'd1,
      PH_FINE   = 3'd2,
      PH_SYNC   = 3'd3,
      PH_FINISH = 3'd4,
      PH_ASYNC  = 3'd5
   } phase_type;

   // Event codes carried by an input item
   typedef enum logic [1:0] {
      FN_ALARM       = 2'd0,
      FN_START_SYNC  = 2'd1,
      FN_START_ASYNC = 2'd2,
      FN_SAMPLE_READ = 2'd3
   } func_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_START_TIME = 2'd0;
   localparam logic [1:0] CSR_DURATION   = 2'd1;
   localparam logic [1:0] CSR_PERIOD     = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 63;
   localparam int unsigned TIME_W      = 63;
   localparam int unsigned ALARM_W     = 64;
   localparam int unsigned PERIOD_W    = 32;
   localparam int unsigned SECONDS_W   = 16;
   localparam int unsigned TICKS_W     = 32;

   // Timer ticks per microsecond of the synchronized clock
   localparam logic [63:0] TICKS_PER_US = 64'd40;
   localparam logic [63:0] US_PER_S     = 64'd1000000;

   // Second count times one million fits in 36 bits
   localparam int unsigned SEC_US_W = 36;

   localparam logic [31:0] PERIOD_RESET = 32'd400000;

endpackage

FILE: rtl/synced_sample_trigger_sequencer_top.sv
// ----------------------------------------------------------------------------
// synced_sample_trigger_sequencer_top
// Six-phase sampling sequencer stepped by timer alarms and control events.
// ----------------------------------------------------------------------------
// Each input item (alarm, start synchronized, start asynchronous, sample read)
// yields exactly one result item carrying the next alarm count in timer ticks,
// the sample strobe, the sticky lost and done flags, the sync status and the
// phase after the step. An accepted item waits in the input register while
// the step logic works on it and is then loaded into the result register once
// that register is empty or its result is taken; a new item may be accepted
// every cycle unless the input stalls, and the input stalls only while both
// registers are full and the result is stalled.
// The step logic is a constant multiply by the tick rate after a 64-bit add,
// set by the re-alignment target start + seconds * 1e6 - now. The seconds
// offset is kept as a running sum so no variable multiply sits in that path.
// Configuration writes take effect at once and must only be made while no
// item is in flight.
// ----------------------------------------------------------------------------
module synced_sample_trigger_sequencer_top #(
   parameter int unsigned SAMPLES_PER_SECOND = 100
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [ssts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ssts_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_func,
   input  logic                                  req_sync_ready,
   input  logic [ssts_pkg::TIME_W-1:0]           req_sync_time_us,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ssts_pkg::ALARM_W-1:0]   rsp_alarm_count,
   output logic                                  rsp_sample_strobe,
   output logic                                  rsp_sample_lost,
   output logic                                  rsp_sampling_done,
   output logic                                  rsp_sync_led,
   output logic [2:0]                            rsp_phase_out
);

   // Width of the signed whole-second test
   localparam int unsigned DIFF_W = 34 + $clog2(SAMPLES_PER_SECOND + 1);
   localparam logic signed [DIFF_W-1:0] SPS_S = DIFF_W'(SAMPLES_PER_SECOND);
   localparam logic [63:0] GENERIC_PERIOD =
      64'(ssts_pkg::TICKS_PER_US * ssts_pkg::US_PER_S / SAMPLES_PER_SECOND);
   localparam logic [63:0] COARSE_LEAD = 64'(ssts_pkg::TICKS_PER_US * ssts_pkg::US_PER_S);

   // Configuration registers
   logic [ssts_pkg::TIME_W-1:0]    start_ff;
   logic [ssts_pkg::SECONDS_W-1:0] duration_ff;
   logic [ssts_pkg::PERIOD_W-1:0]  period_ff;

   // Sequencer state
   ssts_pkg::phase_type            phase_ff, phase_in;
   logic [ssts_pkg::TICKS_W-1:0]   tick_ff, tick_in;
   logic [ssts_pkg::SECONDS_W-1:0] sec_ff, sec_in;
   logic [ssts_pkg::SEC_US_W-1:0]  sec_us_ff, sec_us_in;
   logic                           pending_ff, pending_in;
   logic                           lost_ff, lost_in;
   logic                           done_ff, done_in;

   // Input register
   logic                           in_valid_ff;
   ssts_pkg::func_type             in_func_ff;
   logic                           in_ready_ff;
   logic [ssts_pkg::TIME_W-1:0]    in_now_ff;

   // Result register
   logic                           out_valid_ff;
   logic [63:0]                    alarm_ff, alarm_in;
   logic                           strobe_ff, strobe_in;
   logic                           led_ff;
   ssts_pkg::phase_type            out_phase_ff;
   logic                           out_lost_ff, out_done_ff;

   logic step_fire;
   logic in_fire;

   logic [ssts_pkg::TICKS_W-1:0]   tick_inc;
   logic [ssts_pkg::SECONDS_W-1:0] sec_inc;
   logic [ssts_pkg::SEC_US_W-1:0]  sec_us_inc;
   logic signed [DIFF_W-1:0]       diff;
   logic                           whole_sec;
   logic [63:0]                    start_ext, now_ext, lead_us, target_us;

   // Handshake: result register frees up when empty or taken
   assign step_fire = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign in_fire   = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         duration_ff <= '0;
         period_ff   <= ssts_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ssts_pkg::CSR_START_TIME: start_ff    <= csr_wdata;
            ssts_pkg::CSR_DURATION:   duration_ff <= csr_wdata[ssts_pkg::SECONDS_W-1:0];
            ssts_pkg::CSR_PERIOD:     period_ff   <= csr_wdata[ssts_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_fire) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
      if (in_fire) begin
         in_func_ff  <= ssts_pkg::func_type'(req_func);
         in_ready_ff <= req_sync_ready;
         in_now_ff   <= req_sync_time_us;
      end
   end

   // Whole-second bookkeeping for a sampling tick
   assign tick_inc   = tick_ff + 1'b1;
   assign sec_inc    = sec_ff + 1'b1;
   assign sec_us_inc = (sec_inc == '0) ? '0
                     : sec_us_ff + ssts_pkg::SEC_US_W'(ssts_pkg::US_PER_S);
   assign diff       = $signed({{(DIFF_W - ssts_pkg::TICKS_W){1'b0}}, tick_inc})
                     - DIFF_W'(1)
                     - $signed({{(DIFF_W - ssts_pkg::SECONDS_W){1'b0}}, sec_ff}) * SPS_S;
   assign whole_sec  = diff >= (SPS_S - DIFF_W'(1));

   assign start_ext = {1'b0, start_ff};
   assign now_ext   = {1'b0, in_now_ff};
   assign lead_us   = start_ext - now_ext;
   assign target_us = start_ext + 64'(sec_us_inc) - now_ext;

   // Step the sequencer for the item in the input register
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      sec_in     = sec_ff;
      sec_us_in  = sec_us_ff;
      pending_in = pending_ff;
      lost_in    = lost_ff;
      done_in    = done_ff;
      alarm_in   = '0;
      strobe_in  = 1'b0;
      unique case (in_func_ff)
         ssts_pkg::FN_ALARM: begin
            unique case (phase_ff)
               ssts_pkg::PH_IDLE: begin
                  alarm_in = 64'(period_ff);
               end
               ssts_pkg::PH_COARSE: begin
                  if (in_ready_ff) begin
                     alarm_in = lead_us * ssts_pkg::TICKS_PER_US - COARSE_LEAD;
                     phase_in = ssts_pkg::PH_FINE;
                  end else begin
                     alarm_in = GENERIC_PERIOD;
                  end
               end
               ssts_pkg::PH_FINE: begin
                  if (in_ready_ff) begin
                     alarm_in = lead_us * ssts_pkg::TICKS_PER_US;
                     phase_in = ssts_pkg::PH_SYNC;
                  end else begin
                     alarm_in = GENERIC_PERIOD;
                  end
               end
               ssts_pkg::PH_SYNC, ssts_pkg::PH_ASYNC: begin
                  strobe_in  = 1'b1;
                  tick_in    = tick_inc;
                  pending_in = 1'b1;
                  if (pending_ff) begin
                     lost_in = 1'b1;
                  end
                  alarm_in = 64'(period_ff);
                  if (whole_sec) begin
                     sec_in    = sec_inc;
                     sec_us_in = sec_us_inc;
                     if (sec_inc >= duration_ff) begin
                        phase_in = ssts_pkg::PH_FINISH;
                     end else if (phase_ff == ssts_pkg::PH_SYNC && in_ready_ff) begin
                        alarm_in = target_us * ssts_pkg::TICKS_PER_US;
                     end
                  end
               end
               ssts_pkg::PH_FINISH: begin
                  done_in  = 1'b1;
                  alarm_in = 64'(period_ff);
                  phase_in = ssts_pkg::PH_IDLE;
               end
               default: begin
                  alarm_in = 64'(period_ff);
               end
            endcase
         end
         ssts_pkg::FN_START_SYNC, ssts_pkg::FN_START_ASYNC: begin
            tick_in    = '0;
            sec_in     = '0;
            sec_us_in  = '0;
            pending_in = 1'b0;
            lost_in    = 1'b0;
            done_in    = 1'b0;
            phase_in   = (in_func_ff == ssts_pkg::FN_START_SYNC) ? ssts_pkg::PH_COARSE
                                                                 : ssts_pkg::PH_ASYNC;
         end
         ssts_pkg::FN_SAMPLE_READ: begin
            pending_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Advance state and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ssts_pkg::PH_IDLE;
         tick_ff      <= '0;
         sec_ff       <= '0;
         sec_us_ff    <= '0;
         pending_ff   <= 1'b0;
         lost_ff      <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step_fire) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            sec_ff       <= sec_in;
            sec_us_ff    <= sec_us_in;
            pending_ff   <= pending_in;
            lost_ff      <= lost_in;
            done_ff      <= done_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (step_fire) begin
         alarm_ff     <= alarm_in;
         strobe_ff    <= strobe_in;
         led_ff       <= in_ready_ff;
         out_phase_ff <= phase_in;
         out_lost_ff  <= lost_in;
         out_done_ff  <= done_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_alarm_count   = $signed(alarm_ff);
   assign rsp_sample_strobe = strobe_ff;
   assign rsp_sample_lost   = out_lost_ff;
   assign rsp_sampling_done = out_done_ff;
   assign rsp_sync_led      = led_ff;
   assign rsp_phase_out     = out_phase_ff;

   // A strobe only comes from a sampling phase or its exit to finish
   a_strobe_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_strobe |->
         rsp_phase_out == ssts_pkg::PH_SYNC || rsp_phase_out == ssts_pkg::PH_ASYNC ||
         rsp_phase_out == ssts_pkg::PH_FINISH)
      else $error("sample strobe outside sampling phase");

   // A strobed tick leaves a sample pending
   a_pending_set: assert property (@(posedge clock) disable iff (reset)
      step_fire && strobe_in |=> pending_ff)
      else $error("strobe did not mark sample pending");

   // Lost flag rises only when a sample was still pending
   a_lost_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(lost_ff) |-> $past(pending_ff))
      else $error("lost flag set without pending sample");

   // A start event clears the sticky flags
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      step_fire && (in_func_ff == ssts_pkg::FN_START_SYNC ||
                    in_func_ff == ssts_pkg::FN_START_ASYNC)
      |=> !lost_ff && !done_ff && tick_ff == '0)
      else $error("start event did not clear run state");

endmodule
